>>> rtl/glcd_pkg.sv
`timescale 1ns / 1ps

package glcd_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic [2:0] start_page;
        logic [6:0] start_col;
    } in_word_t;

    typedef struct packed {
        logic       is_data;
        logic       chip_sel;
        logic [7:0] bus_byte;
        logic       last;
    } out_word_t;

    localparam logic [7:0] CMD_SET_PAGE = 8'hB8;
    localparam logic [7:0] CMD_SET_COL  = 8'h40;
    localparam logic [7:0] GAP_BYTE     = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CELL_WIDTH   = 8'd6;
    localparam logic [2:0] LAST_PAGE    = 3'd7;
    localparam int         GLYPH_COUNT  = 95;

    // sequencer steps within one character
    localparam logic [3:0] STEP_PAGE_LEFT  = 4'd0;
    localparam logic [3:0] STEP_PAGE_RIGHT = 4'd1;
    localparam logic [3:0] STEP_COL_FIRST  = 4'd2;
    localparam logic [3:0] STEP_COL_LAST   = 4'd13;
    localparam logic [3:0] STEP_WRAP_LEFT  = 4'd14;
    localparam logic [3:0] STEP_WRAP_RIGHT = 4'd15;

    // 5x7 font, first column in the top byte
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h6264081323,
        40'h3649562050, 40'h0008070000, 40'h00003E4100,
        40'h00413E0000, 40'h0A0A7C0A0A, 40'h08083E0808,
        40'h0000503000, 40'h0808080808, 40'h0000600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h2649494A3C, 40'h0000140000,
        40'h0000140C00, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h3E415D594E,
        40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h304040403F, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h2649494932, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4030403F, 40'h6314081463,
        40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h081414147C,
        40'h7F08040478, 40'h00447D4000, 40'h2040403D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F3C0400, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h1008100810
    };

    function automatic logic [7:0] glyph_byte(input logic [6:0] idx, input logic [2:0] col);
        logic [39:0] row;
        begin
            row = (idx < 7'(GLYPH_COUNT)) ? GLYPH_ROM[idx] : 40'h0;
            case (col)
                3'd0:    glyph_byte = row[39:32];
                3'd1:    glyph_byte = row[31:24];
                3'd2:    glyph_byte = row[23:16];
                3'd3:    glyph_byte = row[15:8];
                3'd4:    glyph_byte = row[7:0];
                default: glyph_byte = GAP_BYTE;
            endcase
        end
    endfunction

endpackage

>>> rtl/glcd_text_char_command_gen_unit.sv
`timescale 1ns / 1ps

// Text renderer for a 128x64 display built from two 64-column controllers.
// Input channel (in_valid/in_ready/in_data): one character word each, with
// first/start_page/start_col to place a new string. Output channel
// (out_valid/out_ready/out_data): one display bus write per word, with last
// set on the final write of each character.
// A drawn character gives 14 bus writes, or 16 when the cursor wraps to the
// next page (set-page is re-sent to both chips). The writes come one per
// cycle while the output is not stalled, from a 4-bit step counter that
// decodes each write from the captured character, column and page. A taken
// character is captured into the step counter and character registers, and
// its first write is then registered into the output register. The next
// character is taken in the cycle that the last write of the current one is
// produced, so writes stream without gaps. A character that arrives while
// halted (past the last page) is taken and gives no writes.
// Reset clears cursor column, page and halt, and empties the output register.
// While out_ready is low a word in the output register is held and the step
// counter waits; in_ready drops until the current character is finished.
module glcd_text_char_command_gen_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  glcd_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output glcd_pkg::out_word_t  out_data
);
    import glcd_pkg::*;

    logic [6:0] cur_column_reg, cur_column_next;
    logic [2:0] cur_page_reg, cur_page_next;
    logic       halted_reg, halted_next;

    logic       active_reg, active_next;
    logic [3:0] step_reg, step_next;
    logic [6:0] base_col_reg;
    logic [2:0] page_reg;
    logic [6:0] glyph_reg;
    logic       resend_reg;

    logic       out_valid_reg, out_valid_next;
    out_word_t  out_data_reg, out_data_next;

    logic       adv;
    logic       last_step;
    logic       in_fire;
    logic       start_work;

    logic [2:0] eff_page;
    logic [6:0] eff_col;
    logic       eff_halt;
    logic [7:0] next_col;
    logic [7:0] eff_ch;

    logic [3:0] k;
    logic [2:0] glyph_col;
    logic [7:0] col_abs;
    logic [2:0] page_out;

    // step counter of an active character advances when the output can take a word
    assign adv       = active_reg && (!out_valid_reg || out_ready);
    assign last_step = resend_reg ? (step_reg == STEP_WRAP_RIGHT)
                                  : (step_reg == STEP_COL_LAST);
    assign in_ready  = !active_reg || (adv && last_step);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        eff_page = in_data.first ? in_data.start_page : cur_page_reg;
        eff_col  = in_data.first ? in_data.start_col : cur_column_reg;
        eff_halt = in_data.first ? 1'b0 : halted_reg;
        next_col = {1'b0, eff_col} + CELL_WIDTH;
        eff_ch   = (in_data.ch < CH_SPACE || in_data.ch > CH_TILDE) ? CH_SPACE : in_data.ch;
        start_work = in_fire && !eff_halt;

        cur_column_next = cur_column_reg;
        cur_page_next   = cur_page_reg;
        halted_next     = halted_reg;
        if (in_fire)
        begin
            cur_column_next = eff_col;
            cur_page_next   = eff_page;
            halted_next     = eff_halt;
            if (!eff_halt)
            begin
                if (next_col[7])
                begin
                    cur_column_next = 7'd0;
                    if (eff_page == LAST_PAGE)
                        halted_next = 1'b1;
                    else
                        cur_page_next = eff_page + 3'd1;
                end
                else
                begin
                    cur_column_next = next_col[6:0];
                end
            end
        end
    end

    // decode the bus write for the current step
    always_comb
    begin
        k         = step_reg - STEP_COL_FIRST;
        glyph_col = k[3:1];
        col_abs   = {1'b0, base_col_reg} + {5'd0, glyph_col};
        page_out  = (step_reg == STEP_WRAP_LEFT || step_reg == STEP_WRAP_RIGHT)
                    ? page_reg + 3'd1 : page_reg;

        out_data_next.last = last_step;
        unique case (step_reg) inside
            STEP_PAGE_LEFT, STEP_WRAP_LEFT:
            begin
                out_data_next.is_data  = 1'b0;
                out_data_next.chip_sel = 1'b0;
                out_data_next.bus_byte = CMD_SET_PAGE | {5'd0, page_out};
            end
            STEP_PAGE_RIGHT, STEP_WRAP_RIGHT:
            begin
                out_data_next.is_data  = 1'b0;
                out_data_next.chip_sel = 1'b1;
                out_data_next.bus_byte = CMD_SET_PAGE | {5'd0, page_out};
            end
            default:
            begin
                out_data_next.is_data  = k[0];
                out_data_next.chip_sel = col_abs[7] | col_abs[6];
                out_data_next.bus_byte = k[0] ? glyph_byte(glyph_reg, glyph_col)
                                              : (CMD_SET_COL | {2'd0, col_abs[5:0]});
            end
        endcase

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        active_next = active_reg;
        step_next   = step_reg;
        if (adv)
        begin
            step_next = step_reg + 4'd1;
            if (last_step)
                active_next = 1'b0;
        end
        if (start_work)
        begin
            active_next = 1'b1;
            step_next   = STEP_PAGE_LEFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_column_reg <= '0;
            cur_page_reg   <= '0;
            halted_reg     <= 1'b0;
            active_reg     <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_column_reg <= cur_column_next;
            cur_page_reg   <= cur_page_next;
            halted_reg     <= halted_next;
            active_reg     <= active_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_work)
        begin
            base_col_reg <= eff_col;
            page_reg     <= eff_page;
            glyph_reg    <= 7'(eff_ch - CH_SPACE);
            resend_reg   <= next_col[7] && (eff_page != LAST_PAGE);
        end
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_halt_parks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (cur_column_reg == 7'd0 && cur_page_reg == LAST_PAGE))
        else $error("halted with cursor not parked");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !resend_reg) |-> (step_reg <= STEP_COL_LAST))
        else $error("step counter ran past column writes");

    a_mid_char_stays_active: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !last_step) |=> (active_reg && out_valid_reg && !out_data_reg.last))
        else $error("character ended before its last write");

    a_last_ends_char: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last_step && !in_valid) |=> (!active_reg && out_data_reg.last))
        else $error("last write did not finish the character");

endmodule
